/* design/rkd_pkg.sv */
// Shared constants, command codes and control structs for the rotary knob classifier.
package rkd_pkg;

   // Widths fixed by the item and register formats
   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int ACC_BITS              = 32;
   localparam int CPD_BITS              = 8;
   localparam int LPM_BITS              = 16;
   localparam int TIME_BITS             = 32;
   localparam int CMD_BITS              = 2;
   localparam int EVENT_BITS            = 2;
   localparam int BYTE_BITS             = 8;
   localparam int CSR_INDEX_BITS        = 2;
   localparam int CSR_DATA_BITS         = 16;

   // Shift-subtract divider: one quotient bit per cycle
   localparam int DIV_STEPS = ACC_BITS;
   localparam int STEP_BITS = $clog2(DIV_STEPS);

   // Command codes
   localparam logic [CMD_BITS-1:0] CMD_POLL  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_DRAIN = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_TAKE  = 2'd2;

   // Press event codes
   localparam logic [EVENT_BITS-1:0] EVENT_NONE  = 2'd0;
   localparam logic [EVENT_BITS-1:0] EVENT_SHORT = 2'd1;
   localparam logic [EVENT_BITS-1:0] EVENT_LONG  = 2'd2;

   // Register indexes and reset values
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COUNTS_PER_DETENT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS_MS     = 2'd1;
   localparam logic [CPD_BITS-1:0]       CPD_RESET             = 8'd1;
   localparam logic [LPM_BITS-1:0]       LPM_RESET             = 16'd700;

   // Controller to datapath
   typedef struct packed {
      logic load_item;   // capture the accepted item
      logic div_start;   // load divider with |accumulator|
      logic div_step;    // one divider iteration
      logic commit;      // update state and load the result register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic needs_divide;  // drain with a nonzero divisor
      logic is_poll;       // held item is a poll
   } dp_status_type;

endpackage

/* design/rkd_if.sv */
// Channel interfaces: request items, result items and register writes.
interface rkd_req_if
   import rkd_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CMD_BITS-1:0]   cmd;
   logic                  reply_ok;
   logic [BYTE_BITS-1:0]  strap_byte;
   logic [BYTE_BITS-1:0]  position_low;
   logic [BYTE_BITS-1:0]  position_high;
   logic [BYTE_BITS-1:0]  button_byte;
   logic [TIME_BITS-1:0]  now_ms;

   modport source (output valid, cmd, reply_ok, strap_byte, position_low, position_high,
                   button_byte, now_ms, input ready);
   modport sink   (input valid, cmd, reply_ok, strap_byte, position_low, position_high,
                   button_byte, now_ms, output ready);
endinterface

interface rkd_rsp_if
   import rkd_pkg::*;
();
   logic                        valid;
   logic                        ready;
   logic signed [ACC_BITS-1:0]  detents;
   logic [EVENT_BITS-1:0]       press_event;
   logic                        button_held;
   logic                        reply_accepted;

   modport source (output valid, detents, press_event, button_held, reply_accepted,
                   input ready);
   modport sink   (input valid, detents, press_event, button_held, reply_accepted,
                   output ready);
endinterface

interface rkd_csr_if
   import rkd_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/rkd_ctrl.sv */
// Controller: sequences decode, iterative divide and commit, and owns result valid.
module rkd_ctrl
   import rkd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type            state_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic                 rsp_valid_ff;

   // Command decode
   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      cmd.load_item = req_valid && req_ready;
      cmd.div_start = (state_ff == ST_DECODE) && status.needs_divide;
      cmd.div_step  = (state_ff == ST_DIVIDE);
      cmd.commit    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

   // State, step count and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.load_item) state_ff <= ST_DECODE;
            end
            ST_DECODE: begin
               step_ff <= '0;
               if (status.needs_divide) state_ff <= ST_DIVIDE;
               else                     state_ff <= ST_FINISH;
            end
            ST_DIVIDE: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_BITS'(DIV_STEPS - 1)) state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (cmd.commit) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase

         // Result register handshake
         if (cmd.commit)     rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

endmodule

/* design/rkd_dp.sv */
// Datapath: registers, knob state, poll update, shift-subtract divider and result register.
module rkd_dp
   import rkd_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // register writes
   input  logic                        csr_write,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_data,
   // request item
   input  logic [CMD_BITS-1:0]         req_cmd,
   input  logic                        req_reply_ok,
   input  logic [BYTE_BITS-1:0]        req_strap_byte,
   input  logic [BYTE_BITS-1:0]        req_position_low,
   input  logic [BYTE_BITS-1:0]        req_position_high,
   input  logic [BYTE_BITS-1:0]        req_button_byte,
   input  logic [TIME_BITS-1:0]        req_now_ms,
   // control
   input  ctrl_cmd_type                cmd,
   output dp_status_type               status,
   // result payload
   output logic signed [ACC_BITS-1:0]  rsp_detents,
   output logic [EVENT_BITS-1:0]       rsp_press_event,
   output logic                        rsp_button_held,
   output logic                        rsp_reply_accepted
);

   localparam int                 WIDE_BITS = ACC_BITS + 2;
   localparam logic [ACC_BITS-1:0] ACC_MAX  = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic [ACC_BITS-1:0] ACC_MIN  = {1'b1, {(ACC_BITS-1){1'b0}}};

   // Configuration
   logic [CPD_BITS-1:0]  cpd_ff;
   logic [LPM_BITS-1:0]  lpm_ff;

   // Held item
   logic [CMD_BITS-1:0]  item_cmd_ff;
   logic                 item_ok_ff;
   logic [BYTE_BITS-1:0] item_strap_ff, item_lo_ff, item_hi_ff, item_btn_ff;
   logic [TIME_BITS-1:0] item_now_ff;

   // Knob state
   logic [ACC_BITS-1:0]      acc_ff, acc_in;
   logic [POSITION_BITS-1:0] last_ff, last_in;
   logic                     seeded_ff, seeded_in;
   logic                     held_ff, held_in;
   logic [TIME_BITS-1:0]     start_ff, start_in;
   logic                     fired_ff, fired_in;
   logic [EVENT_BITS-1:0]    pend_ff, pend_in;

   // Divider
   logic [ACC_BITS-1:0]  quo_ff, quo_in;
   logic [CPD_BITS-1:0]  rem_ff, rem_in;
   logic                 neg_ff, neg_in;

   // Result register
   logic [ACC_BITS-1:0]   detents_ff, detents_in;
   logic [EVENT_BITS-1:0] event_ff, event_in;
   logic                  held_out_ff, accepted_ff, accepted_in;

   // Poll intermediates
   logic                      bad_reply, pressed;
   logic [31:0]               pos_wide;
   logic [POSITION_BITS-1:0]  pos_v, last_eff, delta_raw;
   logic [TIME_BITS-1:0]      start_eff, elapsed;
   logic                      fired_eff;
   logic signed [WIDE_BITS-1:0] sum_wide;
   logic                      sum_ovf;
   logic [CPD_BITS:0]         rem_shift;
   logic                      rem_ge;
   logic [ACC_BITS-1:0]       quo_signed, rem_signed;

   assign status.needs_divide = (item_cmd_ff == CMD_DRAIN) && (cpd_ff != '0);
   assign status.is_poll      = (item_cmd_ff == CMD_POLL);

   // Divider iteration: restoring shift-subtract
   always_comb begin
      rem_shift = {rem_ff, quo_ff[ACC_BITS-1]};
      rem_ge    = rem_shift >= {1'b0, cpd_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      neg_in    = neg_ff;
      if (cmd.div_start) begin
         quo_in = acc_ff[ACC_BITS-1] ? (~acc_ff + 1'b1) : acc_ff;
         rem_in = '0;
         neg_in = acc_ff[ACC_BITS-1];
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[ACC_BITS-2:0], rem_ge};
         rem_in = rem_ge ? CPD_BITS'(rem_shift - {1'b0, cpd_ff}) : CPD_BITS'(rem_shift);
      end
   end

   // Signed quotient and remainder follow the dividend sign
   always_comb begin
      quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
      rem_signed = neg_ff ? (~{{(ACC_BITS-CPD_BITS){1'b0}}, rem_ff} + 1'b1)
                          : {{(ACC_BITS-CPD_BITS){1'b0}}, rem_ff};
   end

   // Poll: reply check, seeding, wrap-safe delta, saturating add, press classify
   always_comb begin
      bad_reply = !item_ok_ff || ((item_strap_ff | item_lo_ff | item_hi_ff | item_btn_ff) == '0);
      pressed   = (item_btn_ff != '0);
      pos_wide  = {{(32-2*BYTE_BITS){1'b0}}, item_hi_ff, item_lo_ff};
      pos_v     = pos_wide[POSITION_BITS-1:0];
      last_eff  = seeded_ff ? last_ff  : pos_v;
      start_eff = seeded_ff ? start_ff : '0;
      fired_eff = seeded_ff && fired_ff;
      delta_raw = pos_v - last_eff;
      sum_wide  = $signed({{2{acc_ff[ACC_BITS-1]}}, acc_ff})
                + $signed({{(WIDE_BITS-POSITION_BITS){delta_raw[POSITION_BITS-1]}}, delta_raw});
      sum_ovf   = (sum_wide[WIDE_BITS-1:ACC_BITS-1] != '0) &&
                  (sum_wide[WIDE_BITS-1:ACC_BITS-1] != '1);

      acc_in      = acc_ff;
      last_in     = last_ff;
      seeded_in   = seeded_ff;
      held_in     = held_ff;
      start_in    = start_ff;
      fired_in    = fired_ff;
      pend_in     = pend_ff;
      detents_in  = '0;
      event_in    = EVENT_NONE;
      accepted_in = 1'b0;
      elapsed     = '0;

      case (item_cmd_ff)
         CMD_POLL: begin
            if (bad_reply) begin
               held_in   = 1'b0;
               pend_in   = EVENT_NONE;
               seeded_in = 1'b0;
            end else begin
               seeded_in   = 1'b1;
               last_in     = pos_v;
               accepted_in = 1'b1;
               if (sum_ovf) acc_in = sum_wide[WIDE_BITS-1] ? ACC_MIN : ACC_MAX;
               else         acc_in = sum_wide[ACC_BITS-1:0];
               start_in = start_eff;
               fired_in = fired_eff;
               if (pressed != held_ff) begin
                  held_in = pressed;
                  if (pressed) begin
                     start_in = item_now_ff;
                     fired_in = 1'b0;
                  end else if (!fired_eff) begin
                     pend_in = EVENT_SHORT;
                  end
               end
               elapsed = item_now_ff - start_in;
               if (held_in && !fired_in &&
                   (elapsed >= {{(TIME_BITS-LPM_BITS){1'b0}}, lpm_ff})) begin
                  fired_in = 1'b1;
                  pend_in  = EVENT_LONG;
               end
            end
         end
         CMD_DRAIN: begin
            if (cpd_ff != '0) begin
               acc_in     = rem_signed;
               detents_in = quo_signed;
            end
         end
         CMD_TAKE: begin
            event_in = pend_ff;
            pend_in  = EVENT_NONE;
         end
         default: begin
            // unused command: state unchanged
         end
      endcase
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cpd_ff    <= CPD_RESET;
         lpm_ff    <= LPM_RESET;
         acc_ff    <= '0;
         last_ff   <= '0;
         seeded_ff <= 1'b0;
         held_ff   <= 1'b0;
         start_ff  <= '0;
         fired_ff  <= 1'b0;
         pend_ff   <= EVENT_NONE;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_COUNTS_PER_DETENT: cpd_ff <= csr_data[CPD_BITS-1:0];
               CSR_LONG_PRESS_MS:     lpm_ff <= csr_data[LPM_BITS-1:0];
               default: ;
            endcase
         end
         if (cmd.commit) begin
            acc_ff    <= acc_in;
            last_ff   <= last_in;
            seeded_ff <= seeded_in;
            held_ff   <= held_in;
            start_ff  <= start_in;
            fired_ff  <= fired_in;
            pend_ff   <= pend_in;
         end
      end
   end

   // Item capture, divider and result payload
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_cmd_ff   <= req_cmd;
         item_ok_ff    <= req_reply_ok;
         item_strap_ff <= req_strap_byte;
         item_lo_ff    <= req_position_low;
         item_hi_ff    <= req_position_high;
         item_btn_ff   <= req_button_byte;
         item_now_ff   <= req_now_ms;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      if (cmd.commit) begin
         detents_ff  <= detents_in;
         event_ff    <= event_in;
         held_out_ff <= held_in;
         accepted_ff <= accepted_in;
      end
   end

   assign rsp_detents        = $signed(detents_ff);
   assign rsp_press_event    = event_ff;
   assign rsp_button_held    = held_out_ff;
   assign rsp_reply_accepted = accepted_ff;

endmodule

/* design/rotary_knob_delta_and_press_classifier.sv */
// Rotary knob detent accumulator and short/long press classifier, top level.
// Takes one command at a time. A poll, a take, an unused command or a drain with a zero
// counts_per_detent passes through capture, decode and commit before its result is
// registered. A drain with a nonzero counts_per_detent runs the shift-subtract
// divider between decode and commit, one quotient bit per cycle. The result sits in
// an output register; the next item is taken while it waits, and that item stalls
// only at its own commit until the previous result has transferred. Register writes
// are always taken.
module rotary_knob_delta_and_press_classifier
   import rkd_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   rkd_req_if.sink   req_bus,
   rkd_rsp_if.source rsp_bus,
   rkd_csr_if.sink   csr_bus
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   assign csr_bus.ready = 1'b1;

   // Controller
   rkd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // Datapath
   rkd_dp #(
      .POSITION_BITS (POSITION_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_bus.valid && csr_bus.ready),
      .csr_index          (csr_bus.index),
      .csr_data           (csr_bus.data),
      .req_cmd            (req_bus.cmd),
      .req_reply_ok       (req_bus.reply_ok),
      .req_strap_byte     (req_bus.strap_byte),
      .req_position_low   (req_bus.position_low),
      .req_position_high  (req_bus.position_high),
      .req_button_byte    (req_bus.button_byte),
      .req_now_ms         (req_bus.now_ms),
      .cmd                (ctrl_cmd),
      .status             (dp_status),
      .rsp_detents        (rsp_bus.detents),
      .rsp_press_event    (rsp_bus.press_event),
      .rsp_button_held    (rsp_bus.button_held),
      .rsp_reply_accepted (rsp_bus.reply_accepted)
   );

   // One item in flight: no transfer in the cycle after one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while an item is in flight");

   // A commit always presents a result
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.commit |=> rsp_bus.valid)
      else $error("commit did not raise result valid");

   // A press event result carries no detents and no poll acceptance
   a_event_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.press_event != EVENT_NONE)) |->
      (rsp_bus.detents == '0) && !rsp_bus.reply_accepted)
      else $error("press event mixed with other result fields");

   // Divider never starts except on a drain of a decoded item
   a_div_only_drain: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.div_start |-> !dp_status.is_poll && $past(ctrl_cmd.load_item))
      else $error("divider started outside a drain");

endmodule
